### rtl/tli_pkg.sv
// tli_pkg: shared types, constants and instruction codes of the tape language interpreter
// no dependencies; imported by every module of the block but tli_ram
`timescale 1ns / 1ps

package tli_pkg;

   localparam int TapeDepth     = 32768;
   localparam int CodeDepth     = 16384;
   localparam int StepLimit     = 256;
   localparam int QueueDepth    = 2;

   localparam int TapeAddrWidth = $clog2(TapeDepth);
   localparam int CodeAddrWidth = $clog2(CodeDepth);
   localparam int CodeLenWidth  = $clog2(CodeDepth + 1);
   localparam int StepWidth     = $clog2(StepLimit + 1);
   localparam int QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // commands on the request channel
   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_RUN     = 2'd1;
   localparam logic [1:0] CMD_SUPPLY  = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   // status codes on the response channel
   localparam logic [2:0] ST_ACK   = 3'd0;
   localparam logic [2:0] ST_OUT   = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_HALT  = 3'd3;
   localparam logic [2:0] ST_FAULT = 3'd4;

   // instruction characters
   localparam logic [7:0] CH_RIGHT = 8'h3E; // >
   localparam logic [7:0] CH_LEFT  = 8'h3C; // <
   localparam logic [7:0] CH_INC   = 8'h2B; // +
   localparam logic [7:0] CH_DEC   = 8'h2D; // -
   localparam logic [7:0] CH_OUT   = 8'h2E; // .
   localparam logic [7:0] CH_IN    = 8'h2C; // ,
   localparam logic [7:0] CH_OPEN  = 8'h5B; // [
   localparam logic [7:0] CH_CLOSE = 8'h5D; // ]

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_LOAD, OP_RUN, OP_SUPPLY, OP_RESTART
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic       end_of_input;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_WAIT, PH_FAULT
   } phase_type;

endpackage

### rtl/tli_ram.sv
// tli_ram: generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tli_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/tli_front.sv
// tli_front: accepts request transactions, decodes the command and queues them
// depends on tli_pkg
`timescale 1ns / 1ps

module tli_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tli_pkg::req_type       req_payload,
   output tli_pkg::queue_out_type queue_out,
   input  logic                   queue_pop
);
   import tli_pkg::*;

   item_type                   entry_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]   count_ff, count_in;
   item_type                   decoded;
   logic                       push;
   logic                       pop;

   always_comb begin
      decoded.data_byte    = req_payload.data_byte;
      decoded.end_of_input = req_payload.end_of_input;
      case (req_payload.command)
         CMD_LOAD:    decoded.op = OP_LOAD;
         CMD_RUN:     decoded.op = OP_RUN;
         CMD_SUPPLY:  decoded.op = OP_SUPPLY;
         CMD_RESTART: decoded.op = OP_RESTART;
         default:     decoded.op = OP_RESTART;
      endcase
   end

   assign req_ready       = (count_ff != QueueCntWidth'(QueueDepth));
   assign push            = req_valid && req_ready;
   assign pop             = queue_pop && (count_ff != '0);
   assign queue_out.valid = (count_ff != '0);
   assign queue_out.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

### rtl/tli_back.sv
// tli_back: execution engine with code store, tape and response register
// depends on tli_pkg and tli_ram
`timescale 1ns / 1ps

module tli_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tli_pkg::queue_out_type queue_out,
   output logic                   queue_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tli_pkg::rsp_type       rsp_payload
);
   import tli_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR   = 6'b000001,
      S_IDLE    = 6'b000010,
      S_FETCH   = 6'b000100,
      S_EXEC    = 6'b001000,
      S_SCAN_RD = 6'b010000,
      S_SCAN_CK = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [CodeLenWidth-1:0]  len_ff, len_in;
   logic [CodeLenWidth-1:0]  ip_ff, ip_in;
   logic [TapeAddrWidth-1:0] dp_ff, dp_in;
   logic [CodeLenWidth-1:0]  sp_ff, sp_in;
   logic [CodeLenWidth-1:0]  nest_ff, nest_in;
   logic                     fwd_ff, fwd_in;
   logic [StepWidth-1:0]     steps_ff, steps_in;
   logic [TapeAddrWidth-1:0] clr_ff, clr_in;
   logic                     clr_ack_ff, clr_ack_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     code_we;
   logic [CodeAddrWidth-1:0] code_raddr;
   logic [7:0]               code_rdata;
   logic                     tape_we;
   logic [TapeAddrWidth-1:0] tape_waddr;
   logic [7:0]               tape_wdata;
   logic [7:0]               tape_rdata;
   logic [CodeLenWidth-1:0]  sp_next;
   logic                     scan_miss;
   logic [CodeLenWidth-1:0]  nest_next;
   logic                     slot_free;

   tli_ram #(.Width(8), .Depth(CodeDepth)) u_code (
      .clock   (clock),
      .wr_en   (code_we),
      .wr_addr (len_ff[CodeAddrWidth-1:0]),
      .wr_data (queue_out.item.data_byte),
      .rd_addr (code_raddr),
      .rd_data (code_rdata)
   );

   tli_ram #(.Width(8), .Depth(TapeDepth)) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_addr (dp_ff),
      .rd_data (tape_rdata)
   );

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // next scan position and end-of-code or start-of-code check
   always_comb begin
      if (fwd_ff) begin
         sp_next   = sp_ff + 1'b1;
         scan_miss = (sp_next >= len_ff);
      end else begin
         sp_next   = sp_ff - 1'b1;
         scan_miss = (sp_ff == '0);
      end
   end

   always_comb begin
      nest_next = nest_ff;
      if (code_rdata == CH_OPEN) begin
         nest_next = fwd_ff ? nest_ff + 1'b1 : nest_ff - 1'b1;
      end else if (code_rdata == CH_CLOSE) begin
         nest_next = fwd_ff ? nest_ff - 1'b1 : nest_ff + 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      len_in       = len_ff;
      ip_in        = ip_ff;
      dp_in        = dp_ff;
      sp_in        = sp_ff;
      nest_in      = nest_ff;
      fwd_in       = fwd_ff;
      steps_in     = steps_ff;
      clr_in       = clr_ff;
      clr_ack_in   = clr_ack_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      queue_pop    = 1'b0;
      code_we      = 1'b0;
      code_raddr   = ip_ff[CodeAddrWidth-1:0];
      tape_we      = 1'b0;
      tape_waddr   = dp_ff;
      tape_wdata   = tape_rdata;

      case (state_ff)
         S_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
            tape_wdata = '0;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == TapeAddrWidth'(TapeDepth - 1)) begin
               state_in = S_IDLE;
               if (clr_ack_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_ACK, out_byte: 8'd0};
               end
               clr_ack_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (queue_out.valid && slot_free) begin
               queue_pop = 1'b1;
               rsp_in    = '{status: ST_ACK, out_byte: 8'd0};
               case (queue_out.item.op)
                  OP_LOAD: begin
                     rsp_valid_in = 1'b1;
                     if (len_ff != CodeLenWidth'(CodeDepth)) begin
                        code_we = 1'b1;
                        len_in  = len_ff + 1'b1;
                     end
                  end
                  OP_RUN: begin
                     if (phase_ff == PH_FAULT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_FAULT;
                     end else if (phase_ff == PH_WAIT) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_WAIT;
                     end else begin
                        steps_in = '0;
                        state_in = S_FETCH;
                     end
                  end
                  OP_SUPPLY: begin
                     rsp_valid_in = 1'b1;
                     if (phase_ff == PH_WAIT) begin
                        tape_we    = 1'b1;
                        tape_wdata = queue_out.item.end_of_input ? 8'hFF
                                                                 : queue_out.item.data_byte;
                        ip_in      = ip_ff + 1'b1;
                        phase_in   = PH_IDLE;
                     end
                  end
                  OP_RESTART: begin
                     ip_in      = '0;
                     dp_in      = '0;
                     nest_in    = '0;
                     phase_in   = PH_IDLE;
                     clr_in     = '0;
                     clr_ack_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_FETCH: begin
            // code byte and current cell are read here, used in the next cycle
            if (steps_ff == StepWidth'(StepLimit)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_ACK, out_byte: 8'd0};
               state_in     = S_IDLE;
            end else if (ip_ff >= len_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_HALT, out_byte: 8'd0};
               state_in     = S_IDLE;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ip_in    = ip_ff + 1'b1;
            steps_in = steps_ff + 1'b1;
            state_in = S_FETCH;
            case (code_rdata)
               CH_RIGHT: begin
                  if (dp_ff == TapeAddrWidth'(TapeDepth - 1)) begin
                     ip_in        = ip_ff;
                     phase_in     = PH_FAULT;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_FAULT, out_byte: 8'd0};
                     state_in     = S_IDLE;
                  end else begin
                     dp_in = dp_ff + 1'b1;
                  end
               end
               CH_LEFT: begin
                  if (dp_ff == '0) begin
                     ip_in        = ip_ff;
                     phase_in     = PH_FAULT;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_FAULT, out_byte: 8'd0};
                     state_in     = S_IDLE;
                  end else begin
                     dp_in = dp_ff - 1'b1;
                  end
               end
               CH_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata + 8'd1;
               end
               CH_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rdata - 8'd1;
               end
               CH_OUT: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_OUT, out_byte: tape_rdata};
                  state_in     = S_IDLE;
               end
               CH_IN: begin
                  ip_in        = ip_ff;
                  phase_in     = PH_WAIT;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_WAIT, out_byte: 8'd0};
                  state_in     = S_IDLE;
               end
               CH_OPEN: begin
                  if (tape_rdata == 8'd0) begin
                     ip_in    = ip_ff;
                     steps_in = steps_ff;
                     sp_in    = ip_ff;
                     nest_in  = CodeLenWidth'(1);
                     fwd_in   = 1'b1;
                     state_in = S_SCAN_RD;
                  end
               end
               CH_CLOSE: begin
                  if (tape_rdata != 8'd0) begin
                     ip_in    = ip_ff;
                     steps_in = steps_ff;
                     sp_in    = ip_ff;
                     nest_in  = CodeLenWidth'(1);
                     fwd_in   = 1'b0;
                     state_in = S_SCAN_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN_RD: begin
            code_raddr = sp_next[CodeAddrWidth-1:0];
            if (scan_miss) begin
               nest_in      = '0;
               phase_in     = PH_FAULT;
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_FAULT, out_byte: 8'd0};
               state_in     = S_IDLE;
            end else begin
               sp_in    = sp_next;
               state_in = S_SCAN_CK;
            end
         end
         S_SCAN_CK: begin
            nest_in = nest_next;
            if (nest_next == '0) begin
               ip_in    = sp_ff + 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = S_FETCH;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         phase_ff     <= PH_IDLE;
         len_ff       <= '0;
         ip_ff        <= '0;
         dp_ff        <= '0;
         nest_ff      <= '0;
         steps_ff     <= '0;
         clr_ff       <= '0;
         clr_ack_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         ip_ff        <= ip_in;
         dp_ff        <= dp_in;
         nest_ff      <= nest_in;
         steps_ff     <= steps_in;
         clr_ff       <= clr_in;
         clr_ack_ff   <= clr_ack_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sp_ff  <= sp_in;
      fwd_ff <= fwd_in;
      rsp_ff <= rsp_in;
   end

endmodule

### rtl/tape_language_interpreter.sv
// tape_language_interpreter: top level of the eight-instruction tape language machine
// depends on tli_pkg, tli_front, tli_back (and through it tli_ram)
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  req_      in         req_valid/req_ready    tli_pkg::req_type (command, data_byte, end_of_input)
//  rsp_      out        rsp_valid/rsp_ready    tli_pkg::rsp_type (status, out_byte)
//
//  load, supply and restart are taken from the idle state of the back end; restart
//    also sweeps the whole tape, one cell a cycle, and answers when the sweep ends
//  a run passes each instruction through fetch and exec, and each code byte in a bracket
//    scan through scan_rd and scan_ck, bounded by a budget of 256 instructions
//  after reset the tape is swept to zero; requests queue but none executes until it ends
//  a two-entry queue lets requests enter while the back end works or the response stalls

module tape_language_interpreter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tli_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tli_pkg::rsp_type rsp_payload
);
   import tli_pkg::*;

   // decoded transactions waiting for the execution engine
   queue_out_type queue_out;
   logic          queue_pop;

   // front end: accept and decode
   tli_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_out   (queue_out),
      .queue_pop   (queue_pop)
   );

   // back end: code store, tape, sequencer and response register
   tli_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_out   (queue_out),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/tli_checker.sv
// tli_port_checker: port-level assertions for the tape language interpreter, bound to the top
// depends on tli_pkg
`timescale 1ns / 1ps

module tli_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input tli_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tli_pkg::rsp_type rsp_payload
);
   import tli_pkg::*;

   // status is always a known code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == ST_ACK || rsp_payload.status == ST_OUT ||
                     rsp_payload.status == ST_WAIT || rsp_payload.status == ST_HALT ||
                     rsp_payload.status == ST_FAULT))
      else $error("unknown status code");

   // only an output transaction carries a byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_OUT) |-> rsp_payload.out_byte == 8'd0)
      else $error("out_byte set without output status");

   // no response straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

bind tape_language_interpreter tli_port_checker u_port_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### tb/sv/tli_checker.sv
// tli_checker: watches both channels of the tape language interpreter, predicts each response
// depends on tli_pkg; instantiated beside the block by the testbench top
`timescale 1ns / 1ps

module tli_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  tli_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  tli_pkg::rsp_type rsp_payload,
   output int               error_count,
   output int               outstanding
);
   import tli_pkg::*;

   logic [7:0]  tape [TapeDepth];
   logic [7:0]  code_mem [CodeDepth];
   int unsigned code_len;
   int unsigned ip;
   int unsigned dp;
   phase_type   phase;
   rsp_type     awaited_rsp [$];

   // bracket partner search with nesting; moves ip only when found
   function automatic bit find_partner(input bit forward);
      int unsigned p;
      int unsigned depth;
      p = ip;
      depth = 1;
      while (depth > 0) begin
         if (forward) begin
            p++;
            if (p >= code_len) return 1'b0;
            if (code_mem[p] == CH_OPEN) depth++;
            else if (code_mem[p] == CH_CLOSE) depth--;
         end else begin
            if (p == 0) return 1'b0;
            p--;
            if (code_mem[p] == CH_CLOSE) depth++;
            else if (code_mem[p] == CH_OPEN) depth--;
         end
      end
      ip = p;
      return 1'b1;
   endfunction

   function automatic rsp_type execute_run();
      rsp_type     r;
      int unsigned steps;
      r = '0;
      if (phase == PH_FAULT) begin
         r.status = ST_FAULT;
         return r;
      end
      if (phase == PH_WAIT) begin
         r.status = ST_WAIT;
         return r;
      end
      for (steps = 0; steps < StepLimit; steps++) begin
         if (ip >= code_len) begin
            r.status = ST_HALT;
            return r;
         end
         case (code_mem[ip])
            CH_RIGHT: begin
               if (dp + 1 >= TapeDepth) begin
                  phase = PH_FAULT;
                  r.status = ST_FAULT;
                  return r;
               end
               dp++;
            end
            CH_LEFT: begin
               if (dp == 0) begin
                  phase = PH_FAULT;
                  r.status = ST_FAULT;
                  return r;
               end
               dp--;
            end
            CH_INC: tape[dp] = tape[dp] + 8'd1;
            CH_DEC: tape[dp] = tape[dp] - 8'd1;
            CH_OUT: begin
               r.status = ST_OUT;
               r.out_byte = tape[dp];
               ip++;
               return r;
            end
            CH_IN: begin
               phase = PH_WAIT;
               r.status = ST_WAIT;
               return r;
            end
            CH_OPEN: begin
               if (tape[dp] == 8'd0 && !find_partner(1'b1)) begin
                  phase = PH_FAULT;
                  r.status = ST_FAULT;
                  return r;
               end
            end
            CH_CLOSE: begin
               if (tape[dp] != 8'd0 && !find_partner(1'b0)) begin
                  phase = PH_FAULT;
                  r.status = ST_FAULT;
                  return r;
               end
            end
            default: ;
         endcase
         ip++;
      end
      r.status = ST_ACK;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (int i = 0; i < TapeDepth; i++) tape[i] = 8'd0;
         code_len = 0;
         ip = 0;
         dp = 0;
         phase = PH_IDLE;
         awaited_rsp.delete();
         error_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            want = '0;
            case (req_payload.command)
               CMD_LOAD: begin
                  if (code_len < CodeDepth) begin
                     code_mem[code_len] = req_payload.data_byte;
                     code_len++;
                  end
               end
               CMD_RUN: want = execute_run();
               CMD_SUPPLY: begin
                  if (phase == PH_WAIT) begin
                     tape[dp] = req_payload.end_of_input ? 8'hFF : req_payload.data_byte;
                     ip++;
                     phase = PH_IDLE;
                  end
               end
               default: begin
                  for (int i = 0; i < TapeDepth; i++) tape[i] = 8'd0;
                  ip = 0;
                  dp = 0;
                  phase = PH_IDLE;
               end
            endcase
            awaited_rsp.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (awaited_rsp.size() == 0) begin
               $error("response with none pending: status %0d out_byte %0d",
                      got.status, got.out_byte);
               error_count <= error_count + 1;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  error_count <= error_count + 1;
               end else if (got.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
                  error_count <= error_count + 1;
               end
            end
         end
      end
      outstanding <= awaited_rsp.size();
   end

endmodule

### tb/sv/testbench.sv
// testbench: stimulus and verdict for the tape language interpreter
// depends on tli_pkg, tape_language_interpreter and tli_checker
`timescale 1ns / 1ps

module testbench;
   import tli_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   int      error_count;
   int      outstanding;

   // idling mode: 0 sender light / receiver heavy, 1 the reverse, 2 no idling
   int idle_mode;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_asked;
   int hold_done;
   int hold_left;
   int sent_count;
   int restarts;

   tape_language_interpreter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   tli_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always_comb begin
      send_idle_pct = (idle_mode == 0) ? 26 : (idle_mode == 1) ? 88 : 0;
      recv_idle_pct = (idle_mode == 0) ? 88 : (idle_mode == 1) ? 26 : 0;
   end

   // receiver side; a requested hold keeps ready low for a long counted stretch
   initial begin
      rsp_ready <= 1'b0;
      hold_done <= 0;
      hold_left <= 0;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         rsp_ready <= 1'b0;
         hold_done <= hold_asked;
         hold_left <= 400;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // one transaction on the request channel; valid holds until accepted
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic eoi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{command: cmd, data_byte: data, end_of_input: eoi};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic load_byte(input logic [7:0] b);
      send_item(CMD_LOAD, b, 1'($urandom));
   endtask

   task automatic run_machine();
      send_item(CMD_RUN, 8'($urandom), 1'($urandom));
   endtask

   // any byte that is not one of the eight instructions
   function automatic logic [7:0] filler_byte();
      logic [7:0] v;
      v = 8'($urandom);
      while (v == CH_RIGHT || v == CH_LEFT || v == CH_INC || v == CH_DEC ||
             v == CH_OUT || v == CH_IN || v == CH_OPEN || v == CH_CLOSE)
         v = 8'($urandom);
      return v;
   endfunction

   // code starts with ",],[>+]": after a restart the first supply picks whether
   // the lone ']' faults, the second whether the tape march runs to the far end
   task automatic restart_and_gate(input logic [7:0] first_in, input logic first_eoi,
                                   input logic [7:0] second_in);
      send_item(CMD_RESTART, 8'($urandom), 1'($urandom));
      restarts++;
      run_machine();
      send_item(CMD_SUPPLY, first_in, first_eoi);
      run_machine();
      send_item(CMD_SUPPLY, second_in, 1'b0);
   endtask

   // short well-formed program piece, then a few blind runs with supplies
   task automatic program_segment();
      int pieces;
      int offset;
      offset = 0;
      pieces = $urandom_range(3, 10);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0: load_byte(CH_INC);
            1: load_byte(CH_DEC);
            2, 9: load_byte(CH_OUT);
            3: load_byte(CH_IN);
            4: begin
               load_byte(CH_RIGHT);
               offset++;
            end
            5: begin
               if (offset > 0) begin
                  load_byte(CH_LEFT);
                  offset--;
               end else begin
                  load_byte(CH_INC);
               end
            end
            6: begin
               load_byte(CH_OPEN);
               load_byte(CH_DEC);
               load_byte(CH_CLOSE);
            end
            7: begin
               load_byte(CH_OPEN);
               load_byte(CH_DEC);
               load_byte(CH_RIGHT);
               load_byte(CH_INC);
               load_byte(CH_LEFT);
               load_byte(CH_CLOSE);
            end
            default: load_byte(filler_byte());
         endcase
      end
      repeat ($urandom_range(1, 5)) begin
         run_machine();
         if ($urandom_range(0, 1) == 1)
            send_item(CMD_SUPPLY, 8'($urandom), ($urandom_range(0, 4) == 0));
      end
   endtask

   initial begin
      req_valid <= 1'b0;
      req_payload <= '0;
      reset <= 1'b1;
      idle_mode = 2;
      hold_asked = 0;
      sent_count = 0;
      restarts = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty code halts, stray supply is ignored
      run_machine();
      send_item(CMD_SUPPLY, 8'hFF, 1'b1);
      run_machine();
      load_byte(CH_IN);
      load_byte(CH_CLOSE);
      load_byte(CH_IN);
      load_byte(CH_OPEN);
      load_byte(CH_RIGHT);
      load_byte(CH_INC);
      load_byte(CH_CLOSE);
      load_byte(CH_OUT);
      load_byte(8'h00);
      load_byte(8'hFF);
      load_byte(CH_RIGHT);
      load_byte(CH_DEC);
      load_byte(CH_OUT);
      load_byte(CH_LEFT);
      run_machine();                       // waits at the first ','
      run_machine();                       // run while waiting answers wait again
      send_item(CMD_SUPPLY, 8'h00, 1'b0);
      run_machine();                       // stray ']' on a zero cell, waits again
      send_item(CMD_SUPPLY, 8'h00, 1'b0);
      run_machine();                       // bracket skipped, outputs zero
      run_machine();                       // wrap to 255 and output
      run_machine();                       // end of code
      restart_and_gate(8'h00, 1'b1, 8'h00); // end of input stores 255: lone ']' faults
      run_machine();                       // fault is sticky

      // random programs under the three idling modes
      while (sent_count < 700) begin
         idle_mode = (sent_count < 240) ? 0 : (sent_count < 470) ? 1 : 2;
         if (idle_mode == 2 && hold_asked == 0) hold_asked = 1;
         if (restarts < 7 && $urandom_range(0, 24) == 0) begin
            if ($urandom_range(0, 3) == 0)
               restart_and_gate(8'($urandom_range(1, 255)), 1'b0, 8'h00);
            else
               restart_and_gate(8'h00, 1'b0, 8'h00);
         end
         program_segment();
      end

      // march to the last tape cell, many budget-limited runs until the move faults
      idle_mode = 2;
      restart_and_gate(8'h00, 1'b0, 8'h01);
      repeat (420) run_machine();

      // replay everything, then an opening bracket with no partner
      restart_and_gate(8'h00, 1'b0, 8'h00);
      repeat (90) begin
         run_machine();
         send_item(CMD_SUPPLY, 8'($urandom), 1'($urandom));
      end
      load_byte(CH_OPEN);
      load_byte(CH_DEC);
      load_byte(CH_CLOSE);
      load_byte(CH_OPEN);
      repeat (10) begin
         run_machine();
         send_item(CMD_SUPPLY, 8'($urandom), 1'b0);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #40000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
